### design/rfrt_pkg.sv
// Shared constants and types for the receive FIFO with retry supervisor.
`timescale 1ns / 1ps
`default_nettype none

package rfrt_pkg;

  // ring buffer keeps one slot free, so it holds FIFO_DEPTH-1 bytes
  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  // request codes
  localparam logic [1:0] REQ_RX    = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_START = 2'd3;

  // register indexes (byte address is 4 * index)
  localparam int         APB_ADDR_W   = 4;
  localparam logic [1:0] REG_WINDOW   = 2'd0;
  localparam logic [1:0] REG_OFFLINE  = 2'd1;
  localparam logic [1:0] REG_ATTEMPTS = 2'd2;

  localparam logic [15:0] WINDOW_RESET   = 16'd2000;
  localparam logic [19:0] OFFLINE_RESET  = 20'd120000;
  localparam logic [2:0]  ATTEMPTS_RESET = 3'd3;

  typedef struct packed {
    logic [15:0] window_ticks;
    logic [19:0] offline_ticks;
    logic [2:0]  max_attempts;
  } cfg_t;

  typedef struct packed {
    logic       pop_valid;
    logic [7:0] pop_data;
    logic       nonempty_after;
  } fifo_stat_t;

  typedef struct packed {
    logic       send_request;
    logic [2:0] attempt_number;
    logic       busy_res;
    logic       success;
    logic       comm_error;
    logic       offline;
  } sup_stat_t;

endpackage

`default_nettype wire

### design/rfrt_req_if.sv
// Request channel: valid/ready handshake carrying one request.
`timescale 1ns / 1ps
`default_nettype none

interface rfrt_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_data;

  modport source (output valid, req_type, rx_data, input ready);
  modport sink   (input valid, req_type, rx_data, output ready);
endinterface

`default_nettype wire

### design/rfrt_res_if.sv
// Result channel: valid/ready handshake carrying one result.
`timescale 1ns / 1ps
`default_nettype none

interface rfrt_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] pop_data;
  logic       pop_valid;
  logic       data_available;
  logic       send_request;
  logic [2:0] attempt_number;
  logic       busy_res;
  logic       success;
  logic       comm_error;
  logic       offline;

  modport source (output valid, pop_data, pop_valid, data_available, send_request,
                  attempt_number, busy_res, success, comm_error, offline,
                  input ready);
  modport sink   (input valid, pop_data, pop_valid, data_available, send_request,
                  attempt_number, busy_res, success, comm_error, offline,
                  output ready);
endinterface

`default_nettype wire

### design/rfrt_cfg.sv
// APB configuration registers: reply window, offline limit, attempt limit.
`timescale 1ns / 1ps
`default_nettype none

module rfrt_cfg
  import rfrt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r.window_ticks  <= WINDOW_RESET;
      cfg_r.offline_ticks <= OFFLINE_RESET;
      cfg_r.max_attempts  <= ATTEMPTS_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW:   cfg_r.window_ticks  <= pwdata[15:0];
        REG_OFFLINE:  cfg_r.offline_ticks <= pwdata[19:0];
        REG_ATTEMPTS: cfg_r.max_attempts  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW:   prdata = {16'd0, cfg_r.window_ticks};
      REG_OFFLINE:  prdata = {12'd0, cfg_r.offline_ticks};
      REG_ATTEMPTS: prdata = {29'd0, cfg_r.max_attempts};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### design/rfrt_fifo.sv
// Receive ring buffer: storage, read/write pointers, pop and fill status.
`timescale 1ns / 1ps
`default_nettype none

module rfrt_fifo
  import rfrt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [1:0] req_type,
  input  wire logic [7:0] rx_data,
  output fifo_stat_t      stat
);

  logic [7:0]       store [FIFO_DEPTH];
  logic [PTR_W-1:0] rd_idx;
  logic [PTR_W-1:0] wr_idx;
  logic [PTR_W-1:0] rd_idx_next;
  logic [PTR_W-1:0] wr_idx_next;
  logic [PTR_W-1:0] wr_inc;
  logic [PTR_W-1:0] rd_inc;
  logic             full;
  logic             empty;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign wr_inc  = ptr_inc(wr_idx);
  assign rd_inc  = ptr_inc(rd_idx);
  assign full    = (wr_inc == rd_idx);
  assign empty   = (rd_idx == wr_idx);
  // a byte arriving on a full buffer is dropped; a pop on empty is refused
  assign do_push = (req_type == REQ_RX) && !full;
  assign do_pop  = (req_type == REQ_POP) && !empty;

  always_comb begin
    wr_idx_next         = do_push ? wr_inc : wr_idx;
    rd_idx_next         = do_pop ? rd_inc : rd_idx;
    stat.pop_valid      = do_pop;
    stat.pop_data       = do_pop ? store[rd_idx] : 8'd0;
    stat.nonempty_after = (rd_idx_next != wr_idx_next);
  end

  always_ff @(posedge clk) begin
    if (step && do_push) begin
      store[wr_idx] <= rx_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      wr_idx <= '0;
    end else if (step) begin
      rd_idx <= rd_idx_next;
      wr_idx <= wr_idx_next;
    end
  end

`ifndef SYNTHESIS
  a_full_push_drops: assert property (@(posedge clk) disable iff (rst)
    step && (req_type == REQ_RX) && full |=> $stable(wr_idx))
    else $error("push on full buffer moved write pointer");
  a_empty_pop_refused: assert property (@(posedge clk) disable iff (rst)
    step && (req_type == REQ_POP) && empty |=> $stable(rd_idx))
    else $error("pop on empty buffer moved read pointer");
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    step && do_push |=> (rd_idx != wr_idx))
    else $error("buffer empty after a stored byte");
`endif

endmodule

`default_nettype wire

### design/rfrt_sup.sv
// Retry supervisor: reply window, attempt count, silence and offline tracking.
`timescale 1ns / 1ps
`default_nettype none

module rfrt_sup
  import rfrt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [1:0] req_type,
  input  wire logic       nonempty_after,
  input  wire cfg_t       cfg,
  output sup_stat_t       stat
);

  logic [15:0] window_count;
  logic [19:0] silence_count;
  logic [2:0]  attempt_count;
  logic        waiting;
  logic        success_flag;
  logic        error_flag;
  logic        offline_flag;

  logic [15:0] window_count_next;
  logic [19:0] silence_count_next;
  logic [2:0]  attempt_count_next;
  logic        waiting_next;
  logic        success_flag_next;
  logic        error_flag_next;
  logic        offline_flag_next;
  logic        send;
  logic [15:0] window_inc;

  assign window_inc = (window_count == '1) ? window_count : window_count + 1'b1;

  always_comb begin
    window_count_next  = window_count;
    silence_count_next = silence_count;
    attempt_count_next = attempt_count;
    waiting_next       = waiting;
    success_flag_next  = success_flag;
    error_flag_next    = error_flag;
    offline_flag_next  = offline_flag;
    send               = 1'b0;

    case (req_type)
      REQ_RX: begin
        silence_count_next = '0;
        offline_flag_next  = 1'b0;
        if (waiting && nonempty_after) begin
          success_flag_next = 1'b1;
          error_flag_next   = 1'b0;
          waiting_next      = 1'b0;
        end
      end
      REQ_POP: ;
      REQ_TICK: begin
        if (silence_count != '1) begin
          silence_count_next = silence_count + 1'b1;
        end
        if (waiting) begin
          window_count_next = window_inc;
          if (window_inc >= cfg.window_ticks) begin
            // retry while attempt_count + 1 < max_attempts
            if ({1'b0, attempt_count} + 4'd1 < {1'b0, cfg.max_attempts}) begin
              attempt_count_next = attempt_count + 1'b1;
              window_count_next  = '0;
              send               = 1'b1;
            end else begin
              waiting_next    = 1'b0;
              error_flag_next = 1'b1;
            end
          end
        end
      end
      REQ_START: begin
        success_flag_next  = 1'b0;
        attempt_count_next = '0;
        window_count_next  = '0;
        waiting_next       = 1'b1;
        send               = 1'b1;
        // reply already buffered counts as success at once
        if (nonempty_after) begin
          success_flag_next = 1'b1;
          error_flag_next   = 1'b0;
          waiting_next      = 1'b0;
        end
      end
      default: ;
    endcase

    if (waiting_next && (silence_count_next >= cfg.offline_ticks)) begin
      offline_flag_next = 1'b1;
    end

    stat.send_request   = send;
    stat.attempt_number = attempt_count_next;
    stat.busy_res       = waiting_next;
    stat.success        = success_flag_next;
    stat.comm_error     = error_flag_next;
    stat.offline        = offline_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count  <= '0;
      silence_count <= '0;
      attempt_count <= '0;
      waiting       <= 1'b0;
      success_flag  <= 1'b0;
      error_flag    <= 1'b0;
      offline_flag  <= 1'b0;
    end else if (step) begin
      window_count  <= window_count_next;
      silence_count <= silence_count_next;
      attempt_count <= attempt_count_next;
      waiting       <= waiting_next;
      success_flag  <= success_flag_next;
      error_flag    <= error_flag_next;
      offline_flag  <= offline_flag_next;
    end
  end

`ifndef SYNTHESIS
  a_success_ends_wait: assert property (@(posedge clk) disable iff (rst)
    !(waiting && success_flag))
    else $error("success flagged while still waiting");
  a_offline_while_waiting: assert property (@(posedge clk) disable iff (rst)
    $rose(offline_flag) |-> waiting)
    else $error("offline raised outside a reply window");
  a_error_closes_window: assert property (@(posedge clk) disable iff (rst)
    $rose(error_flag) |-> !waiting)
    else $error("error raised with window still open");
`endif

endmodule

`default_nettype wire

### design/rx_fifo_with_retry_timeout.sv
// Top level: request register, single-pass FIFO/supervisor update, result register.
`timescale 1ns / 1ps
`default_nettype none

// Receive FIFO with command retry supervisor. Every request (received byte,
// pop, tick, send start) produces exactly one result carrying the status after
// that request. A request is taken into an input register, and the buffer
// pointers, counters and flags are updated in one pass of logic as it moves to
// the result register, so one request per clock is sustained while results drain.
// The input side accepts while a result waits if the result register drains, and
// stalls only when both hold an item and res.ready is low. The buffer holds up
// to FIFO_DEPTH-1 bytes; bytes arriving while it is full are dropped. No clearing
// pass is needed after reset. Registers are written over APB at byte offsets 0x0
// (reply window ticks), 0x4 (offline ticks) and 0x8 (attempt limit). The user must
// write them only while no request is in flight; the block does not enforce this.
module rx_fifo_with_retry_timeout
  import rfrt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  rfrt_req_if.sink                   req,
  rfrt_res_if.source                 res,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  cfg_t       cfg;
  fifo_stat_t fifo_stat;
  sup_stat_t  sup_stat;

  logic       in_valid;
  logic [1:0] in_type;
  logic [7:0] in_data;
  logic       step;
  logic       res_valid;

  rfrt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // request in the input register moves on when the result slot is free or draining
  assign step      = in_valid && (!res_valid || res.ready);
  assign req.ready = !in_valid || step;
  assign res.valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_type <= req.req_type;
      in_data <= req.rx_data;
    end
  end

  rfrt_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .req_type (in_type),
    .rx_data  (in_data),
    .stat     (fifo_stat)
  );

  rfrt_sup u_sup (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .req_type       (in_type),
    .nonempty_after (fifo_stat.nonempty_after),
    .cfg            (cfg),
    .stat           (sup_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.pop_data       <= fifo_stat.pop_data;
      res.pop_valid      <= fifo_stat.pop_valid;
      res.data_available <= fifo_stat.nonempty_after;
      res.send_request   <= sup_stat.send_request;
      res.attempt_number <= sup_stat.attempt_number;
      res.busy_res       <= sup_stat.busy_res;
      res.success        <= sup_stat.success;
      res.comm_error     <= sup_stat.comm_error;
      res.offline        <= sup_stat.offline;
    end
  end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the receive FIFO with retry supervisor.
`timescale 1ns / 1ps

module testbench;
  import rfrt_pkg::*;

  typedef struct packed {
    logic [7:0] pop_data;
    logic       pop_valid;
    logic       data_available;
    logic       send_request;
    logic [2:0] attempt_number;
    logic       busy_res;
    logic       success;
    logic       comm_error;
    logic       offline;
  } rx_status_t;

  typedef struct packed {
    logic [1:0] ph;
    logic [1:0] rq;
    logic [7:0] data;
    logic       fixed;
    rx_status_t want;
  } dir_row_t;

  localparam int DIR_N       = 25;
  localparam int RND_PHASES  = 12;
  localparam int RND_ITEMS   = 130;
  localparam int SETTLE_CYC  = 4;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  rfrt_req_if req_if();
  rfrt_res_if res_if();

  rx_fifo_with_retry_timeout u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  cfg_t             sup_cfg;
  logic [7:0]       ring [FIFO_DEPTH];
  logic [PTR_W-1:0] rd_ptr, wr_ptr;
  logic [15:0]      win_cnt;
  logic [19:0]      silence_cnt;
  logic [2:0]       att_cnt;
  logic             waiting, succ_flag, err_flag, offl_flag;

  rx_status_t pending_status [$];
  rx_status_t got_status;
  int         mismatch_count = 0;
  dir_row_t   dir_tab [DIR_N];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic void take_reply();
    succ_flag = 1'b1;
    err_flag  = 1'b0;
    waiting   = 1'b0;
  endfunction

  function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic rx_status_t fifo_sup_step(input logic [1:0] rq, input logic [7:0] b);
    rx_status_t r;
    logic [PTR_W-1:0] nxt;
    r = '0;
    case (rq)
      REQ_RX: begin
        nxt = ring_inc(wr_ptr);
        if (nxt != rd_ptr) begin
          ring[wr_ptr] = b;
          wr_ptr = nxt;
        end
        silence_cnt = '0;
        offl_flag = 1'b0;
        if (waiting && rd_ptr != wr_ptr) take_reply();
      end
      REQ_POP: begin
        if (rd_ptr != wr_ptr) begin
          r.pop_data  = ring[rd_ptr];
          r.pop_valid = 1'b1;
          rd_ptr = ring_inc(rd_ptr);
        end
      end
      REQ_TICK: begin
        if (silence_cnt != '1) silence_cnt = silence_cnt + 1'b1;
        if (waiting) begin
          if (win_cnt != '1) win_cnt = win_cnt + 1'b1;
          if (win_cnt >= sup_cfg.window_ticks) begin
            if (int'(att_cnt) + 1 < int'(sup_cfg.max_attempts)) begin
              att_cnt = att_cnt + 1'b1;
              win_cnt = '0;
              r.send_request = 1'b1;
            end else begin
              waiting  = 1'b0;
              err_flag = 1'b1;
            end
          end
        end
      end
      default: begin
        succ_flag = 1'b0;
        att_cnt   = '0;
        win_cnt   = '0;
        waiting   = 1'b1;
        r.send_request = 1'b1;
        if (rd_ptr != wr_ptr) take_reply();
      end
    endcase
    if (waiting && silence_cnt >= sup_cfg.offline_ticks) offl_flag = 1'b1;
    r.data_available = (rd_ptr != wr_ptr);
    r.attempt_number = att_cnt;
    r.busy_res       = waiting;
    r.success        = succ_flag;
    r.comm_error     = err_flag;
    r.offline        = offl_flag;
    return r;
  endfunction

  task automatic chk_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      got_status = '{res_if.pop_data, res_if.pop_valid, res_if.data_available,
                     res_if.send_request, res_if.attempt_number, res_if.busy_res,
                     res_if.success, res_if.comm_error, res_if.offline};
      if (pending_status.size() == 0) begin
        $display("%0t ns: result with no request pending, expected none actual %h",
                 $time, got_status);
        mismatch_count++;
      end else begin
        rx_status_t w;
        w = pending_status.pop_front();
        chk_field("pop_data", w.pop_data, got_status.pop_data);
        chk_field("pop_valid", w.pop_valid, got_status.pop_valid);
        chk_field("data_available", w.data_available, got_status.data_available);
        chk_field("send_request", w.send_request, got_status.send_request);
        chk_field("attempt_number", w.attempt_number, got_status.attempt_number);
        chk_field("busy_res", w.busy_res, got_status.busy_res);
        chk_field("success", w.success, got_status.success);
        chk_field("comm_error", w.comm_error, got_status.comm_error);
        chk_field("offline", w.offline, got_status.offline);
      end
    end
  end

  // result side stalls on its own pattern, picking a new style at random
  initial begin : res_stall
    int mode;
    int cnt;
    mode = 0;
    cnt = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cnt % 64 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= ($urandom_range(0, 3) != 0);
        default: res_if.ready <= ((cnt % 8) >= 3);
      endcase
      cnt++;
    end
  end

  task automatic send_req(input logic [1:0] rq, input logic [7:0] b, input logic fixed,
                          input rx_status_t want);
    rx_status_t p;
    @(negedge clk);
    req_if.valid    <= 1'b1;
    req_if.req_type <= rq;
    req_if.rx_data  <= b;
    do @(posedge clk); while (!req_if.ready);
    p = fifo_sup_step(rq, b);
    pending_status.push_back(fixed ? want : p);
  endtask

  task automatic idle_req(input int n);
    if (n > 0) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    idle_req(1);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_WINDOW:  sup_cfg.window_ticks  = value[15:0];
      REG_OFFLINE: sup_cfg.offline_ticks = value[19:0];
      default:     sup_cfg.max_attempts  = value[2:0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_cfg(input logic [15:0] w, input logic [19:0] o, input logic [2:0] a);
    apb_write(REG_WINDOW, {16'd0, w});
    apb_write(REG_OFFLINE, {12'd0, o});
    apb_write(REG_ATTEMPTS, {29'd0, a});
  endtask

  initial begin : stim
    int i, ph, cur_ph, burst_left, pick, total;
    int w_rx, w_pop, w_tick, w_start;
    bit no_gap;
    logic [1:0] rq;

    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_RX;
    req_if.rx_data = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    sup_cfg = '{WINDOW_RESET, OFFLINE_RESET, ATTEMPTS_RESET};
    rd_ptr = '0;
    wr_ptr = '0;
    win_cnt = '0;
    silence_cnt = '0;
    att_cnt = '0;
    waiting = 1'b0;
    succ_flag = 1'b0;
    err_flag = 1'b0;
    offl_flag = 1'b0;

    dir_tab = '{
      // reset settings: empty pop, fill and drain, start with and without data
      '{2'd0, REQ_POP,   8'h00, 1'b1, '0},
      '{2'd0, REQ_TICK,  8'h00, 1'b1, '0},
      '{2'd0, REQ_RX,    8'h00, 1'b1, '{data_available:1, default:0}},
      '{2'd0, REQ_POP,   8'h00, 1'b1, '{pop_valid:1, default:0}},
      '{2'd0, REQ_RX,    8'hFF, 1'b1, '{data_available:1, default:0}},
      '{2'd0, REQ_START, 8'h00, 1'b1,
        '{data_available:1, send_request:1, success:1, default:0}},
      '{2'd0, REQ_POP,   8'h00, 1'b1,
        '{pop_data:8'hFF, pop_valid:1, success:1, default:0}},
      '{2'd0, REQ_START, 8'h00, 1'b1, '{send_request:1, busy_res:1, default:0}},
      '{2'd0, REQ_RX,    8'hA5, 1'b1, '{data_available:1, success:1, default:0}},
      '{2'd0, REQ_POP,   8'h00, 1'b1,
        '{pop_data:8'hA5, pop_valid:1, success:1, default:0}},
      '{2'd0, REQ_START, 8'h00, 1'b1, '{send_request:1, busy_res:1, default:0}},
      '{2'd0, REQ_START, 8'h00, 1'b1, '{send_request:1, busy_res:1, default:0}},
      // short window: retry, go offline, give up, recover
      '{2'd1, REQ_START, 8'h00, 1'b0, '0},
      '{2'd1, REQ_TICK,  8'h00, 1'b0, '0},
      '{2'd1, REQ_TICK,  8'h00, 1'b0, '0},
      '{2'd1, REQ_TICK,  8'h00, 1'b0, '0},
      '{2'd1, REQ_TICK,  8'h00, 1'b0, '0},
      '{2'd1, REQ_RX,    8'h5A, 1'b0, '0},
      '{2'd1, REQ_START, 8'h00, 1'b0, '0},
      '{2'd1, REQ_POP,   8'h00, 1'b0, '0},
      // all-zero settings
      '{2'd2, REQ_START, 8'h00, 1'b0, '0},
      '{2'd2, REQ_TICK,  8'h00, 1'b0, '0},
      '{2'd2, REQ_RX,    8'h3C, 1'b0, '0},
      '{2'd2, REQ_POP,   8'h00, 1'b0, '0},
      '{2'd2, REQ_TICK,  8'h00, 1'b0, '0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cur_ph = 0;
    for (i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].ph != cur_ph) begin
        settle();
        cur_ph = dir_tab[i].ph;
        if (cur_ph == 1) set_cfg(16'd2, 20'd3, 3'd2);
        else set_cfg(16'd0, 20'd0, 3'd0);
      end
      send_req(dir_tab[i].rq, dir_tab[i].data, dir_tab[i].fixed, dir_tab[i].want);
    end

    for (ph = 0; ph < RND_PHASES; ph++) begin
      settle();
      case (ph)
        0: set_cfg(16'd1, 20'd1, 3'd1);
        1: set_cfg(16'hFFFF, 20'hFFFFF, 3'd7);
        default:
          if ($urandom_range(0, 5) == 0)
            set_cfg(16'($urandom_range(1, 65535)), 20'($urandom_range(1, 1048575)),
                    3'($urandom_range(1, 7)));
          else
            set_cfg(16'($urandom_range(1, 12)), 20'($urandom_range(1, 40)),
                    3'($urandom_range(1, 7)));
      endcase
      // per-phase mix so some phases fill the ring and others drain it
      w_rx    = $urandom_range(10, 40);
      w_pop   = $urandom_range(10, 40);
      w_tick  = $urandom_range(20, 50);
      w_start = $urandom_range(3, 10);
      total   = w_rx + w_pop + w_tick + w_start;
      no_gap  = (ph % 4 == 3);
      burst_left = 0;
      for (i = 0; i < RND_ITEMS; i++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (!no_gap) idle_req($urandom_range(0, 6));
        end
        burst_left--;
        pick = $urandom_range(0, total - 1);
        if (pick < w_rx) rq = REQ_RX;
        else if (pick < w_rx + w_pop) rq = REQ_POP;
        else if (pick < w_rx + w_pop + w_tick) rq = REQ_TICK;
        else rq = REQ_START;
        send_req(rq, 8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    idle_req(1);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
